FILE: rtl/core/crt_pkg.sv
// Package with shared types, command codes and constants of the command ring tracker.
`default_nettype none

package crt_pkg;

  // Default number of command slots in the ring.
  localparam int unsigned QueueDepthDefault = 16;
  // Number of parameter words stored with each command.
  localparam int unsigned NumParams = 6;
  // Depth of the queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);

  // Command codes on the input channel.
  localparam logic [2:0] CMD_ENQUEUE = 3'd0;
  localparam logic [2:0] CMD_SEND    = 3'd1;
  localparam logic [2:0] CMD_ACK     = 3'd2;
  localparam logic [2:0] CMD_MESSAGE = 3'd3;
  localparam logic [2:0] CMD_DEQUEUE = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  // Operation classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_ENQUEUE,
    OP_SEND,
    OP_ACK,
    OP_MESSAGE,
    OP_DEQUEUE,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot_index;
    logic [31:0] cont_tag;
    logic [31:0] target_word;
    logic [31:0] command_id;
    logic [31:0] param_a;
    logic [31:0] param_b;
    logic [31:0] param_c;
    logic [31:0] param_d;
    logic [31:0] param_e;
    logic [31:0] param_f;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_out;
    logic [31:0] sent_target;
    logic [31:0] sent_id;
    logic [31:0] sent_p0;
    logic [31:0] sent_p1;
    logic [31:0] sent_p2;
    logic [31:0] sent_p3;
    logic [31:0] sent_p4;
    logic [31:0] sent_p5;
    logic [4:0]  queue_level;
    logic [31:0] enqueue_total;
  } out_item_t;

  // One stored command, as held in the slot memory.
  typedef struct packed {
    logic [31:0]                target;
    logic [31:0]                id;
    logic [NumParams-1:0][31:0] params;
  } cmd_rec_t;

  // A classified operation travelling from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [3:0]  slot_index;
    logic        deq_in_range;
    logic [31:0] cont_tag;
    cmd_rec_t    rec;
  } op_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/crt_front.sv
// Front end: accepts input transfers, classifies them and queues them for the back end.
`default_nettype none

module crt_front #(
  parameter int unsigned QUEUE_DEPTH = crt_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire crt_pkg::in_item_t in_data_i,
  output logic                   op_valid_o,
  input  wire logic              op_ready_i,
  output crt_pkg::op_item_t      op_o
);

  crt_pkg::op_item_t                entry_q [crt_pkg::FifoDepth];
  crt_pkg::op_item_t                dec;
  logic [crt_pkg::FifoPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [crt_pkg::FifoPtrW:0]       cnt_q, cnt_d;
  logic                             push, pop;

  // Classify the command code and check the dequeue index against the ring size.
  always_comb begin
    dec.slot_index   = in_data_i.slot_index;
    dec.deq_in_range = (32'(in_data_i.slot_index) < 32'(QUEUE_DEPTH));
    dec.cont_tag     = in_data_i.cont_tag;
    dec.rec.target   = in_data_i.target_word;
    dec.rec.id       = in_data_i.command_id;
    dec.rec.params   = {in_data_i.param_f, in_data_i.param_e, in_data_i.param_d,
                        in_data_i.param_c, in_data_i.param_b, in_data_i.param_a};
    unique case (in_data_i.cmd)
      crt_pkg::CMD_ENQUEUE: dec.op = crt_pkg::OP_ENQUEUE;
      crt_pkg::CMD_SEND:    dec.op = crt_pkg::OP_SEND;
      crt_pkg::CMD_ACK:     dec.op = crt_pkg::OP_ACK;
      crt_pkg::CMD_MESSAGE: dec.op = crt_pkg::OP_MESSAGE;
      crt_pkg::CMD_DEQUEUE: dec.op = crt_pkg::OP_DEQUEUE;
      crt_pkg::CMD_CLEAR:   dec.op = crt_pkg::OP_CLEAR;
      default:              dec.op = crt_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != (crt_pkg::FifoPtrW+1)'(crt_pkg::FifoDepth));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = entry_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == crt_pkg::FifoPtrW'(crt_pkg::FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == crt_pkg::FifoPtrW'(crt_pkg::FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/crt_back.sv
// Back end: slot flags, tag match, dispatch scan, command memory and the result register.
`default_nettype none

module crt_back #(
  parameter int unsigned QUEUE_DEPTH = crt_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              op_valid_i,
  output logic                   op_ready_o,
  input  wire crt_pkg::op_item_t op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output crt_pkg::out_item_t     out_data_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSend  = 2'd1;
  localparam logic [1:0] StMatch = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [QUEUE_DEPTH-1:0] ready_q, ready_d, sent_q, sent_d, done_q, done_d;
  logic [31:0]            tag_q [QUEUE_DEPTH];
  logic [IdxW-1:0]        fill_q, fill_d, send_q, send_d, scan_q, scan_d;
  logic [31:0]            total_q, total_d;
  logic [LvlW-1:0]        level_q, level_d;
  logic [QUEUE_DEPTH-1:0] match_q, match_d, match_vec, stop_vec;
  logic [31:0]            tag_hold_q, tag_hold_d;
  logic                   is_msg_q, is_msg_d;
  crt_pkg::cmd_rec_t      mem [QUEUE_DEPTH];
  crt_pkg::cmd_rec_t      rd_rec_q;
  logic                   mem_we, rd_en, tag_we, out_load, out_free, out_valid_q;
  crt_pkg::out_item_t     res, out_q;
  logic [IdxW-1:0]        scan_idx, match_idx, deq_idx, fill_next;
  logic [IdxW:0]          scan_pos;
  logic                   scan_found;
  logic [IdxW+3:0]        deq_ext;

  function automatic logic [3:0] slot4(input logic [IdxW-1:0] idx);
    logic [IdxW+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  function automatic logic [4:0] level5(input logic [LvlW-1:0] lvl);
    logic [LvlW+4:0] ext;
    ext = {5'b00000, lvl};
    return ext[4:0];
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign deq_ext   = {{IdxW{1'b0}}, op_i.slot_index};
  assign deq_idx   = deq_ext[IdxW-1:0];
  assign fill_next = (fill_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : fill_q + 1'b1;

  // Dispatch scan: first slot at or after the send pointer, in ring order, that is not
  // both sent and done or that sits at the fill pointer; the send pointer if none.
  always_comb begin
    logic [2*QUEUE_DEPTH-1:0] dbl;
    logic [IdxW:0]            sum;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      stop_vec[i]  = !(sent_q[i] && done_q[i]) || (IdxW'(i) == fill_q);
      match_vec[i] = (tag_q[i] == op_i.cont_tag) && ready_q[i] && sent_q[i];
    end
    dbl        = {stop_vec, stop_vec};
    scan_found = 1'b0;
    scan_pos   = '0;
    for (int j = 2 * QUEUE_DEPTH - 1; j >= 0; j--) begin
      if (dbl[j] && (j >= int'(send_q))) begin
        scan_found = 1'b1;
        scan_pos   = (IdxW+1)'(j);
      end
    end
    sum      = scan_found ? scan_pos : {1'b0, send_q};
    scan_idx = (sum >= (IdxW+1)'(QUEUE_DEPTH)) ? IdxW'(sum - (IdxW+1)'(QUEUE_DEPTH))
                                               : IdxW'(sum);
  end

  // Lowest matching slot.
  always_comb begin
    match_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    ready_d    = ready_q;
    sent_d     = sent_q;
    done_d     = done_q;
    fill_d     = fill_q;
    send_d     = send_q;
    scan_d     = scan_q;
    total_d    = total_q;
    level_d    = level_q;
    match_d    = match_q;
    tag_hold_d = tag_hold_q;
    is_msg_d   = is_msg_q;
    op_ready_o = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    tag_we     = 1'b0;
    res        = '0;

    unique case (state_q)
      StIdle: begin
        if (op_valid_i) begin
          unique case (op_i.op) inside
            crt_pkg::OP_SEND: begin
              op_ready_o = 1'b1;
              rd_en      = 1'b1;
              scan_d     = scan_idx;
              tag_hold_d = op_i.cont_tag;
              state_d    = StSend;
            end
            crt_pkg::OP_ACK, crt_pkg::OP_MESSAGE: begin
              op_ready_o = 1'b1;
              match_d    = match_vec;
              is_msg_d   = (op_i.op == crt_pkg::OP_MESSAGE);
              state_d    = StMatch;
            end
            default: begin
              if (out_free) begin
                op_ready_o = 1'b1;
                out_load   = 1'b1;
                case (op_i.op)
                  crt_pkg::OP_ENQUEUE: begin
                    res.slot_out = slot4(fill_q);
                    if (!ready_q[fill_q]) begin
                      ready_d[fill_q] = 1'b1;
                      sent_d[fill_q]  = 1'b0;
                      done_d[fill_q]  = 1'b0;
                      mem_we          = 1'b1;
                      fill_d          = fill_next;
                      total_d         = total_q + 32'd1;
                      level_d         = level_q + 1'b1;
                      res.ok          = 1'b1;
                    end
                  end
                  crt_pkg::OP_DEQUEUE: begin
                    res.slot_out = op_i.slot_index;
                    if (op_i.deq_in_range) begin
                      res.ok           = ready_q[deq_idx];
                      if (ready_q[deq_idx]) begin
                        level_d = level_q - 1'b1;
                      end
                      ready_d[deq_idx] = 1'b0;
                      sent_d[deq_idx]  = 1'b1;
                      done_d[deq_idx]  = 1'b1;
                    end
                  end
                  crt_pkg::OP_CLEAR: begin
                    ready_d = '0;
                    sent_d  = '1;
                    done_d  = '1;
                    fill_d  = '0;
                    send_d  = '0;
                    total_d = '0;
                    level_d = '0;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
      StSend: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
          if (ready_q[scan_q] && !sent_q[scan_q]) begin
            sent_d[scan_q]  = 1'b1;
            send_d          = scan_q;
            tag_we          = 1'b1;
            res.ok          = 1'b1;
            res.slot_out    = slot4(scan_q);
            res.sent_target = rd_rec_q.target;
            res.sent_id     = rd_rec_q.id;
            res.sent_p0     = rd_rec_q.params[0];
            res.sent_p1     = rd_rec_q.params[1];
            res.sent_p2     = rd_rec_q.params[2];
            res.sent_p3     = rd_rec_q.params[3];
            res.sent_p4     = rd_rec_q.params[4];
            res.sent_p5     = rd_rec_q.params[5];
          end
        end
      end
      StMatch: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
          if (match_q != '0) begin
            res.ok       = 1'b1;
            res.slot_out = slot4(match_idx);
            if (is_msg_q) begin
              done_d[match_idx] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    res.queue_level   = level5(level_d);
    res.enqueue_total = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ready_q     <= '0;
      sent_q      <= '1;
      done_q      <= '1;
      fill_q      <= '0;
      send_q      <= '0;
      total_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      sent_q      <= sent_d;
      done_q      <= done_d;
      fill_q      <= fill_d;
      send_q      <= send_d;
      total_q     <= total_d;
      level_q     <= level_d;
      out_valid_q <= out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    match_q    <= match_d;
    tag_hold_q <= tag_hold_d;
    is_msg_q   <= is_msg_d;
    if (tag_we) begin
      tag_q[scan_q] <= tag_hold_q;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  // Command memory: one write port for enqueue, one registered read port for dispatch.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q] <= op_i.rec;
    end
    if (rd_en) begin
      rd_rec_q <= mem[scan_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/command_ring_tracker_top.sv
// Top level of the command ring tracker: front end, operation queue and back end.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (crt_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (crt_pkg::out_item_t)
//
// Each input transfer yields one output transfer, in order, via a two-entry operation queue.
// The back end handles enqueue, dequeue, clear and unused codes in its idle state; send, ack
// and message pass through a second state: a scan or tag compare, then the read data or lowest
// match commits. Short operations sustain one item per cycle while the output is not stalled.
// Reset at once clears ready flags, pointers and counters and sets the sent and done flags.
// An output stall holds the back end while the queue fills.

module command_ring_tracker_top #(
  parameter int unsigned QUEUE_DEPTH = crt_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire crt_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output crt_pkg::out_item_t     out_data_o
);

  // Classified operations between the front end and the back end.
  logic              op_valid;
  logic              op_ready;
  crt_pkg::op_item_t op_item;

  crt_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op_item)
  );

  // The back end owns all slot state, so operations commit strictly in arrival order.
  crt_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
